### hw/rtl/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ECC_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ecc assertion failed");

// Clocked assertion that is also checked during reset.
`define ECC_ASSERT_NR(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("ecc assertion failed");

`endif

### hw/rtl/ecc_pkg.sv
// Types, constants and arithmetic helpers of the circle collision pipeline.
`default_nettype none

package ecc_pkg;

    localparam int IN_W   = 384;  // input tdata width, fields padded to bytes
    localparam int IN_USE = 380;  // bits of input tdata that carry fields
    localparam int OUT_W  = 192;  // output tdata width
    localparam int SQ_ST  = 32;   // square root stages, one root bit each
    localparam int DV_ST  = 31;   // normal divider stages, one quotient bit each
    localparam int FR_ST  = 4;    // front stages
    localparam int BK_ST  = 6;    // back stages
    // Register stages behind the input register, output register included.
    localparam int NUM_ST = FR_ST + (SQ_ST + 1) + (DV_ST + 1) + BK_ST + 1;

    localparam logic [31:0] QONE = 32'h4000_0000;  // 1.0 in Q2.30

    typedef struct packed {
        logic signed [31:0] vx1;
        logic signed [31:0] vy1;
        logic signed [31:0] vx2;
        logic signed [31:0] vy2;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic        [31:0] rsum;
    } t_carry;

    typedef struct packed {
        t_carry      c;
        logic        sx;
        logic        sy;
        logic        zero;
        logic [32:0] ax;
        logic [32:0] ay;
        logic [30:0] m1;
        logic [30:0] m2;
        logic [31:0] tot;
        logic [1:0]  rsh;
        logic [4:0]  lsh;
        logic [61:0] sqx;
        logic [61:0] sqy;
    } t_front;

    typedef struct packed {
        t_carry      c;
        logic        sx;
        logic        sy;
        logic        zero;
        logic        totz;
        logic [30:0] axn;
        logic [30:0] ayn;
        logic [63:0] rem;
        logic [31:0] root;
        logic [63:0] wr1;
        logic [63:0] wr2;
        logic [31:0] wq1;
        logic [31:0] wq2;
        logic [31:0] tot;
    } t_mid;

    typedef struct packed {
        t_carry      c;
        logic        sx;
        logic        sy;
        logic        zero;
        logic [31:0] len;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [30:0] qx;
        logic [30:0] qy;
        logic [31:0] w1;
        logic [31:0] w2;
    } t_div;

    typedef struct packed {
        logic               snx;
        logic               sny;
        logic [30:0]        nxm;
        logic [30:0]        nym;
        logic [31:0]        w1;
        logic [31:0]        w2;
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic [7:0][32:0]   p;
        logic signed [33:0] pushx;
        logic signed [33:0] pushy;
        logic signed [33:0] dpn1;
        logic signed [33:0] dpn2;
        logic signed [33:0] dpt1;
        logic signed [33:0] dpt2;
        logic signed [31:0] posx;
        logic signed [31:0] posy;
        logic signed [34:0] diff;
        logic signed [37:0] m1p;
        logic signed [37:0] m2p;
        logic signed [35:0] e1;
        logic signed [35:0] e2;
        logic [7:0][36:0]   q;
    } t_back;

    function automatic logic [35:0] mag36(input logic signed [35:0] v);
        return v[35] ? 36'(-v) : 36'(v);
    endfunction

    // Product of two magnitudes with a Q2.30 factor, truncated toward zero.
    function automatic logic signed [38:0] mulq(input logic [35:0] am,
                                                input logic [31:0] bm,
                                                input logic neg);
        logic [67:0] p;
        logic [37:0] s;
        p = {32'd0, am} * {36'd0, bm};
        s = p[67:30];
        return neg ? -$signed({1'b0, s}) : $signed({1'b0, s});
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
        if (v > 38'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -38'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

endpackage

`default_nettype wire

### hw/rtl/elastic_circle_collision.sv
// Top level of the elastic collision pipeline for two circles.
//
// One input transaction on the slave channel carries one colliding pair:
// centres, velocities, radii and masses of both circles, Q16.16. One output
// transaction on the master channel returns the second circle's corrected
// centre and both new velocities, each saturated to 32-bit Q16.16.
// The block is a fully pipelined datapath: a new pair may enter in every
// cycle and results leave in the order of entry, one per pair.
// A pair passes the input, front, root, divider, back and output registers
// before its result shows on o_m_tvalid. The depth is set by the square root
// (one root bit a stage, 32 stages) and the divider for the unit normal
// (one quotient bit a stage, 31 stages); the mass weights are divided in the
// same stages as the root. Sustained throughput is one transaction per cycle.
// When the receiver holds i_m_tready low with a result waiting, the whole
// pipeline freezes; the input register still takes one more transaction if
// it is empty, so o_s_tready only drops once that slot is also full.
// Nothing is dropped or repeated across a stall.
// Reset (i_rst_n low at a clock edge) clears every valid bit; the payload
// registers are left as they are and carry no meaning until refilled.
`default_nettype none

module elastic_circle_collision (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_tvalid,
    output logic                         o_s_tready,
    // first_x, first_y, first_vx, first_vy, first_radius, first_mass,
    // second_x, second_y, second_vx, second_vy, second_radius, second_mass,
    // then four zero bits
    input  wire  [ecc_pkg::IN_W-1:0]     i_s_tdata,
    output logic                         o_m_tvalid,
    input  wire                          i_m_tready,
    // second_new_x, second_new_y, first_next_vx, first_next_vy,
    // second_next_vx, second_next_vy
    output logic [ecc_pkg::OUT_W-1:0]    o_m_tdata
);
    import ecc_pkg::*;

    // Handshake control. The whole pipeline moves on en_g; the input
    // register may also fill while the rest is frozen.
    logic en_g;
    logic en0;

    logic                r_v0;
    logic [IN_USE-1:0]   r_in;
    logic [NUM_ST-1:0]   r_vld;
    logic [NUM_ST-1:0]   n_vld;

    t_front r_fr [FR_ST];
    t_front n_fr [FR_ST];
    t_mid   r_sq [SQ_ST+1];
    t_mid   n_sq [SQ_ST+1];
    t_div   r_dv [DV_ST+1];
    t_div   n_dv [DV_ST+1];
    t_back  r_bk [BK_ST];
    t_back  n_bk [BK_ST];
    logic [OUT_W-1:0] r_out;
    logic [OUT_W-1:0] n_out;

    assign en_g       = ~r_vld[NUM_ST-1] | i_m_tready;
    assign en0        = ~r_v0 | en_g;
    assign o_s_tready = en0;
    assign o_m_tvalid = r_vld[NUM_ST-1];
    assign o_m_tdata  = r_out;
    assign n_vld      = {r_vld[NUM_ST-2:0], r_v0};

    // Front: differences, magnitudes, then scaling so that the larger
    // magnitude lies in [2^30, 2^31), then the squares.
    always_comb begin
        logic signed [31:0] x1, y1, x2, y2;
        logic signed [32:0] dx, dy;
        logic [30:0]        r1, r2, m1, m2;
        logic [32:0]        mx;
        logic [32:0]        shx, shy;

        x1 = r_in[31:0];
        y1 = r_in[63:32];
        r1 = r_in[158:128];
        m1 = r_in[189:159];
        x2 = r_in[221:190];
        y2 = r_in[253:222];
        r2 = r_in[348:318];
        m2 = r_in[379:349];
        dx = 33'(x2) - 33'(x1);
        dy = 33'(y2) - 33'(y1);

        n_fr[0]        = '0;
        n_fr[0].c.x1   = x1;
        n_fr[0].c.y1   = y1;
        n_fr[0].c.vx1  = r_in[95:64];
        n_fr[0].c.vy1  = r_in[127:96];
        n_fr[0].c.vx2  = r_in[285:254];
        n_fr[0].c.vy2  = r_in[317:286];
        n_fr[0].c.rsum = {1'b0, r1} + {1'b0, r2};
        n_fr[0].sx     = dx[32];
        n_fr[0].sy     = dy[32];
        n_fr[0].zero   = (dx == '0) && (dy == '0);
        n_fr[0].ax     = dx[32] ? 33'(-dx) : 33'(dx);
        n_fr[0].ay     = dy[32] ? 33'(-dy) : 33'(dy);
        n_fr[0].m1     = m1;
        n_fr[0].m2     = m2;
        n_fr[0].tot    = {1'b0, m1} + {1'b0, m2};

        // Shift amount: right by one or two, or left up to 30 places.
        mx      = (r_fr[0].ax > r_fr[0].ay) ? r_fr[0].ax : r_fr[0].ay;
        n_fr[1] = r_fr[0];
        n_fr[1].lsh = '0;
        for (int i = 0; i < 31; i++) begin
            if (mx[i]) begin
                n_fr[1].lsh = 5'(30 - i);
            end
        end
        if (mx[32]) begin
            n_fr[1].rsh = 2'd2;
        end else if (mx[31]) begin
            n_fr[1].rsh = 2'd1;
        end else begin
            n_fr[1].rsh = 2'd0;
        end

        if (r_fr[1].rsh != 2'd0) begin
            shx = r_fr[1].ax >> r_fr[1].rsh;
            shy = r_fr[1].ay >> r_fr[1].rsh;
        end else begin
            shx = r_fr[1].ax << r_fr[1].lsh;
            shy = r_fr[1].ay << r_fr[1].lsh;
        end
        n_fr[2]    = r_fr[1];
        n_fr[2].ax = {2'b00, shx[30:0]};
        n_fr[2].ay = {2'b00, shy[30:0]};

        n_fr[3]     = r_fr[2];
        n_fr[3].sqx = r_fr[2].ax[30:0] * r_fr[2].ax[30:0];
        n_fr[3].sqy = r_fr[2].ay[30:0] * r_fr[2].ay[30:0];
    end

    // Setup of the root and of the two mass weight divisions, then the
    // square root, one root bit per stage, plus one weight bit per stage.
    always_comb begin
        logic [64:0] trial;
        logic [63:0] wd;
        int          b;
        n_sq[0]      = '0;
        n_sq[0].c    = r_fr[3].c;
        n_sq[0].sx   = r_fr[3].sx;
        n_sq[0].sy   = r_fr[3].sy;
        n_sq[0].zero = r_fr[3].zero;
        n_sq[0].totz = (r_fr[3].tot == '0);
        n_sq[0].axn  = r_fr[3].ax[30:0];
        n_sq[0].ayn  = r_fr[3].ay[30:0];
        n_sq[0].rem  = 64'({1'b0, r_fr[3].sqx} + {1'b0, r_fr[3].sqy});
        n_sq[0].wr1  = {2'b00, r_fr[3].m1, 31'd0};
        n_sq[0].wr2  = {2'b00, r_fr[3].m2, 31'd0};
        n_sq[0].tot  = r_fr[3].tot;
        for (int k = 0; k < SQ_ST; k++) begin
            b         = SQ_ST - 1 - k;
            n_sq[k+1] = r_sq[k];
            trial     = (65'(r_sq[k].root) << (b + 1)) | (65'd1 << (2 * b));
            if ({1'b0, r_sq[k].rem} >= trial) begin
                n_sq[k+1].rem  = 64'({1'b0, r_sq[k].rem} - trial);
                n_sq[k+1].root = r_sq[k].root | (32'd1 << b);
            end
            wd = 64'(r_sq[k].tot) << b;
            if (r_sq[k].wr1 >= wd) begin
                n_sq[k+1].wr1 = r_sq[k].wr1 - wd;
                n_sq[k+1].wq1 = r_sq[k].wq1 | (32'd1 << b);
            end
            if (r_sq[k].wr2 >= wd) begin
                n_sq[k+1].wr2 = r_sq[k].wr2 - wd;
                n_sq[k+1].wq2 = r_sq[k].wq2 | (32'd1 << b);
            end
        end
    end

    // Unit normal: each scaled magnitude times 2^30 over the length.
    always_comb begin
        logic [63:0] d;
        int          b;
        n_dv[0]      = '0;
        n_dv[0].c    = r_sq[SQ_ST].c;
        n_dv[0].sx   = r_sq[SQ_ST].sx;
        n_dv[0].sy   = r_sq[SQ_ST].sy;
        n_dv[0].zero = r_sq[SQ_ST].zero;
        n_dv[0].len  = r_sq[SQ_ST].root;
        n_dv[0].rx   = 64'(r_sq[SQ_ST].axn) << 30;
        n_dv[0].ry   = 64'(r_sq[SQ_ST].ayn) << 30;
        // Both masses zero count as equal masses.
        n_dv[0].w1   = r_sq[SQ_ST].totz ? QONE : r_sq[SQ_ST].wq1;
        n_dv[0].w2   = r_sq[SQ_ST].totz ? QONE : r_sq[SQ_ST].wq2;
        for (int k = 0; k < DV_ST; k++) begin
            b         = DV_ST - 1 - k;
            n_dv[k+1] = r_dv[k];
            d         = 64'(r_dv[k].len) << b;
            if (r_dv[k].rx >= d) begin
                n_dv[k+1].rx = r_dv[k].rx - d;
                n_dv[k+1].qx = r_dv[k].qx | (31'd1 << b);
            end
            if (r_dv[k].ry >= d) begin
                n_dv[k+1].ry = r_dv[k].ry - d;
                n_dv[k+1].qy = r_dv[k].qy | (31'd1 << b);
            end
        end
    end

    // Back end: projections, momentum exchange, recombination.
    always_comb begin
        logic signed [31:0] vv [4];
        logic [35:0]        vm [4];
        logic signed [38:0] pr;
        logic signed [38:0] pa, pb, pc, pd;
        logic [35:0]        dm, tm, em;
        logic               ts, es;
        logic signed [37:0] sa, sb;

        // Stage one: normal in sign and magnitude, then eight products
        // of velocity and normal plus the two push products.
        vv[0] = r_dv[DV_ST].c.vx1;
        vv[1] = r_dv[DV_ST].c.vy1;
        vv[2] = r_dv[DV_ST].c.vx2;
        vv[3] = r_dv[DV_ST].c.vy2;
        for (int i = 0; i < 4; i++) begin
            vm[i] = mag36(36'(vv[i]));
        end
        n_bk[0]     = '0;
        n_bk[0].snx = r_dv[DV_ST].sx & ~r_dv[DV_ST].zero;
        n_bk[0].sny = r_dv[DV_ST].sy & ~r_dv[DV_ST].zero;
        n_bk[0].nxm = r_dv[DV_ST].zero ? QONE[30:0] : r_dv[DV_ST].qx;
        n_bk[0].nym = r_dv[DV_ST].zero ? '0 : r_dv[DV_ST].qy;
        n_bk[0].w1  = r_dv[DV_ST].w1;
        n_bk[0].w2  = r_dv[DV_ST].w2;
        n_bk[0].x1  = r_dv[DV_ST].c.x1;
        n_bk[0].y1  = r_dv[DV_ST].c.y1;
        for (int i = 0; i < 2; i++) begin
            pa = mulq(vm[2*i], 32'(n_bk[0].nxm), vv[2*i][31] ^ n_bk[0].snx);
            pb = mulq(vm[2*i+1], 32'(n_bk[0].nym), vv[2*i+1][31] ^ n_bk[0].sny);
            pc = mulq(vm[2*i], 32'(n_bk[0].nym), vv[2*i][31] ^ n_bk[0].sny);
            pd = mulq(vm[2*i+1], 32'(n_bk[0].nxm), vv[2*i+1][31] ^ n_bk[0].snx);
            n_bk[0].p[4*i]   = pa[32:0];
            n_bk[0].p[4*i+1] = pb[32:0];
            n_bk[0].p[4*i+2] = pc[32:0];
            n_bk[0].p[4*i+3] = pd[32:0];
        end
        pr = mulq(36'(r_dv[DV_ST].c.rsum), 32'(n_bk[0].nxm), n_bk[0].snx);
        n_bk[0].pushx = pr[33:0];
        pr = mulq(36'(r_dv[DV_ST].c.rsum), 32'(n_bk[0].nym), n_bk[0].sny);
        n_bk[0].pushy = pr[33:0];

        // Stage two: normal and tangent dot products, pushed centre.
        // The tangent is (-ny, nx).
        n_bk[1]      = r_bk[0];
        n_bk[1].dpn1 = 34'($signed(r_bk[0].p[0])) + 34'($signed(r_bk[0].p[1]));
        n_bk[1].dpt1 = 34'($signed(r_bk[0].p[3])) - 34'($signed(r_bk[0].p[2]));
        n_bk[1].dpn2 = 34'($signed(r_bk[0].p[4])) + 34'($signed(r_bk[0].p[5]));
        n_bk[1].dpt2 = 34'($signed(r_bk[0].p[7])) - 34'($signed(r_bk[0].p[6]));
        n_bk[1].posx = sat32(38'(r_bk[0].x1) + 38'(r_bk[0].pushx));
        n_bk[1].posy = sat32(38'(r_bk[0].y1) + 38'(r_bk[0].pushy));

        // Stage three: difference of the normal speeds.
        n_bk[2]      = r_bk[1];
        n_bk[2].diff = 35'(r_bk[1].dpn2) - 35'(r_bk[1].dpn1);

        // Stage four: difference times each mass weight.
        dm           = mag36(36'(r_bk[2].diff));
        n_bk[3]      = r_bk[2];
        pr           = mulq(dm, r_bk[2].w2, r_bk[2].diff[34]);
        n_bk[3].m1p  = pr[37:0];
        pr           = mulq(dm, r_bk[2].w1, ~r_bk[2].diff[34]);
        n_bk[3].m2p  = pr[37:0];

        // Stage five: normal speeds after the exchange.
        n_bk[4]    = r_bk[3];
        sa         = 38'(r_bk[3].dpn1) + r_bk[3].m1p;
        sb         = 38'(r_bk[3].dpn2) + r_bk[3].m2p;
        n_bk[4].e1 = sa[35:0];
        n_bk[4].e2 = sb[35:0];

        // Stage six: back to x and y: a = ny*dpt, b = nx*e, c = nx*dpt,
        // d = ny*e, for each circle.
        n_bk[5] = r_bk[4];
        for (int i = 0; i < 2; i++) begin
            tm = mag36(36'((i == 0) ? r_bk[4].dpt1 : r_bk[4].dpt2));
            ts = (i == 0) ? r_bk[4].dpt1[33] : r_bk[4].dpt2[33];
            em = mag36((i == 0) ? r_bk[4].e1 : r_bk[4].e2);
            es = (i == 0) ? r_bk[4].e1[35] : r_bk[4].e2[35];
            pa = mulq(tm, 32'(r_bk[4].nym), ts ^ r_bk[4].sny);
            pb = mulq(em, 32'(r_bk[4].nxm), es ^ r_bk[4].snx);
            pc = mulq(tm, 32'(r_bk[4].nxm), ts ^ r_bk[4].snx);
            pd = mulq(em, 32'(r_bk[4].nym), es ^ r_bk[4].sny);
            n_bk[5].q[4*i]   = pa[36:0];
            n_bk[5].q[4*i+1] = pb[36:0];
            n_bk[5].q[4*i+2] = pc[36:0];
            n_bk[5].q[4*i+3] = pd[36:0];
        end
    end

    // Output stage: final sums and saturation.
    always_comb begin
        logic signed [31:0] fvx, fvy, svx, svy;
        fvx = sat32(38'($signed(r_bk[5].q[1])) - 38'($signed(r_bk[5].q[0])));
        fvy = sat32(38'($signed(r_bk[5].q[2])) + 38'($signed(r_bk[5].q[3])));
        svx = sat32(38'($signed(r_bk[5].q[5])) - 38'($signed(r_bk[5].q[4])));
        svy = sat32(38'($signed(r_bk[5].q[6])) + 38'($signed(r_bk[5].q[7])));
        n_out = {svy, svx, fvy, fvx, r_bk[5].posy, r_bk[5].posx};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0  <= 1'b0;
            r_vld <= '0;
        end else begin
            if (en0) begin
                r_v0 <= i_s_tvalid;
            end
            if (en_g) begin
                r_vld <= n_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_in <= i_s_tdata[IN_USE-1:0];
        end
        if (en_g) begin
            r_fr  <= n_fr;
            r_sq  <= n_sq;
            r_dv  <= n_dv;
            r_bk  <= n_bk;
            r_out <= n_out;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ecc_check.sv
// Port-level assertion checker for the collision pipeline, with its bind.
`default_nettype none
`include "assert_macros.svh"

module ecc_check (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_tready,
    input wire                        i_out_tvalid,
    input wire                        i_out_tready,
    input wire [ecc_pkg::OUT_W-1:0]   i_out_tdata
);
    import ecc_pkg::*;

    logic [OUT_W-1:0] w_data;
    assign w_data = i_out_tdata;

    // A pending result stays offered until it is taken.
    `ECC_ASSERT(a_out_hold, i_clk, i_rst_n, i_out_tvalid && !i_out_tready |=> i_out_tvalid)
    // Reset empties the pipeline, so no result follows it at once.
    `ECC_ASSERT_NR(a_rst_empty, i_clk, !i_rst_n |=> !i_out_tvalid)
    // With no result waiting the pipeline moves, so the input is open.
    `ECC_ASSERT_NR(a_idle_ready, i_clk, !i_out_tvalid |-> i_in_tready)
    // A taking receiver never blocks the input side.
    `ECC_ASSERT_NR(a_flow_ready, i_clk, i_out_tready |-> i_in_tready)
    // A stalled result keeps its data.
    `ECC_ASSERT(a_out_stable, i_clk, i_rst_n, i_out_tvalid && !i_out_tready |=> $stable(w_data))

endmodule

bind elastic_circle_collision ecc_check u_ecc_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_tready (o_s_tready),
    .i_out_tvalid(o_m_tvalid),
    .i_out_tready(i_m_tready),
    .i_out_tdata (o_m_tdata)
);

`default_nettype wire

### tb/tb.sv
// Self-checking stream testbench for the elastic circle collision pipeline.
`timescale 1ns / 1ps

module tb;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 160;
    localparam int LONG_HOLD      = 300;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_s_tvalid;
    logic                       o_s_tready;
    logic [ecc_pkg::IN_W-1:0]   i_s_tdata;
    logic                       o_m_tvalid;
    logic                       i_m_tready;
    logic [ecc_pkg::OUT_W-1:0]  o_m_tdata;

    elastic_circle_collision u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    logic [ecc_pkg::IN_W-1:0]  pairs_pending[$];
    logic [ecc_pkg::OUT_W-1:0] collisions_due[$];
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Collision predictor, exact integer arithmetic.
    // ---------------------------------------------------------------
    function automatic longint sx32(input logic [31:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint unsigned abs64(input longint v);
        return v < 0 ? longint'(0) - v : v;
    endfunction

    // Truncated product with a Q2.30 factor, sign applied afterwards.
    function automatic longint qmul(input longint a, input longint b);
        longint unsigned p;
        p = (abs64(a) * abs64(b)) >> 30;
        return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned num);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > num) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (num >= res + bitv) begin
                num = num - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic longint mass_weight(input longint unsigned mine,
                                           input longint unsigned other);
        longint unsigned tot;
        tot = mine + other;
        if (tot == 0) return longint'(ecc_pkg::QONE);
        return longint'((mine << 31) / tot);
    endfunction

    function automatic logic [ecc_pkg::OUT_W-1:0] predict_collision(
            input logic [ecc_pkg::IN_W-1:0] d);
        longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy, nx, ny, tx, ty;
        longint rsum, dpt1, dpt2, dpn1, dpn2, w1, w2, e1, e2;
        longint unsigned r1, m1, r2, m2, ax, ay, mx, len;
        x1  = sx32(d[31:0]);    y1  = sx32(d[63:32]);
        vx1 = sx32(d[95:64]);   vy1 = sx32(d[127:96]);
        r1  = d[158:128];       m1  = d[189:159];
        x2  = sx32(d[221:190]); y2  = sx32(d[253:222]);
        vx2 = sx32(d[285:254]); vy2 = sx32(d[317:286]);
        r2  = d[348:318];       m2  = d[379:349];
        dx = x2 - x1;
        dy = y2 - y1;
        ax = abs64(dx);
        ay = abs64(dy);
        if (ax == 0 && ay == 0) begin
            // Coincident centres push along +x.
            nx = longint'(ecc_pkg::QONE);
            ny = 0;
        end else begin
            mx = ax > ay ? ax : ay;
            while (mx >= (64'd1 << 31)) begin
                ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
            end
            while (mx < (64'd1 << 30)) begin
                ax = ax << 1; ay = ay << 1; mx = mx << 1;
            end
            len = root64(ax * ax + ay * ay);
            nx = longint'((ax << 30) / len);
            ny = longint'((ay << 30) / len);
            if (dx < 0) nx = -nx;
            if (dy < 0) ny = -ny;
        end
        rsum = longint'(r1 + r2);
        tx = -ny;
        ty = nx;
        dpt1 = qmul(vx1, tx) + qmul(vy1, ty);
        dpt2 = qmul(vx2, tx) + qmul(vy2, ty);
        dpn1 = qmul(vx1, nx) + qmul(vy1, ny);
        dpn2 = qmul(vx2, nx) + qmul(vy2, ny);
        w1 = mass_weight(m1, m2);
        w2 = mass_weight(m2, m1);
        e1 = dpn1 + qmul(dpn2 - dpn1, w2);
        e2 = dpn2 + qmul(dpn1 - dpn2, w1);
        return {clip32(qmul(ty, dpt2) + qmul(ny, e2)),
                clip32(qmul(tx, dpt2) + qmul(nx, e2)),
                clip32(qmul(ty, dpt1) + qmul(ny, e1)),
                clip32(qmul(tx, dpt1) + qmul(nx, e1)),
                clip32(y1 + qmul(ny, rsum)),
                clip32(x1 + qmul(nx, rsum))};
    endfunction

    function automatic logic [ecc_pkg::IN_W-1:0] pack_pair(
            input logic [31:0] x1, y1, vx1, vy1, input logic [30:0] r1, m1,
            input logic [31:0] x2, y2, vx2, vy2, input logic [30:0] r2, m2);
        return {4'b0, m2, r2, vy2, vx2, y2, x2, m1, r1, vy1, vx1, y1, x1};
    endfunction

    function automatic logic [30:0] rand_pos31();
        logic [30:0] v;
        v = 31'($urandom);
        return v == 0 ? 31'd1 : v;
    endfunction

    // Signed value in +/- lim whole units with a random fraction, Q16.16.
    function automatic logic [31:0] rand_q(input int lim);
        int v;
        v = $urandom_range(2 * lim * 65536) - lim * 65536;
        return 32'(v);
    endfunction

    // Mostly nearby pairs of moderate size, mass and speed, some full-range noise.
    task automatic add_random_pair();
        logic [31:0] x1, y1;
        logic [30:0] r1, r2;
        if ($urandom_range(99) < 25) begin
            pairs_pending.push_back(pack_pair($urandom, $urandom, $urandom, $urandom,
                rand_pos31(), rand_pos31(), $urandom, $urandom, $urandom, $urandom,
                rand_pos31(), rand_pos31()));
        end else begin
            x1 = rand_q(1000);
            y1 = rand_q(1000);
            r1 = 31'($urandom_range(50 * 65536, 65536));
            r2 = 31'($urandom_range(50 * 65536, 65536));
            pairs_pending.push_back(pack_pair(x1, y1, rand_q(100), rand_q(100), r1,
                31'($urandom_range(100 * 65536, 1)),
                x1 + rand_q(60), y1 + rand_q(60), rand_q(100), rand_q(100), r2,
                31'($urandom_range(100 * 65536, 1))));
        end
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pairs_pending.size() != 0 || i_s_tvalid || collisions_due.size() != 0);
    endtask

    task automatic run_phase(input int count, input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        repeat (count) add_random_pair();
        wait_idle();
    endtask

    // ---------------------------------------------------------------
    // Driver: presents pending pairs and records each accepted one.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            i_s_tdata  <= '0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                collisions_due.push_back(predict_collision(i_s_tdata));
            end
            if (!i_s_tvalid || o_s_tready) begin
                if (pairs_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_s_tdata  <= pairs_pending.pop_front();
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver backpressure, with a long hold-off on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack   <= hold_req;
            hold_left  <= LONG_HOLD;
            i_m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= $urandom_range(99) >= recv_stall_pct;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: compares each result transaction with the oldest prediction.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [ecc_pkg::OUT_W-1:0] want;
        string field_names[6];
        field_names = '{"second_new_x", "second_new_y", "first_next_vx",
                        "first_next_vy", "second_next_vx", "second_next_vy"};
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (collisions_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", o_m_tdata);
                end else begin
                    want = collisions_due.pop_front();
                    for (int f = 0; f < 6; f++) begin
                        if (want[32*f +: 32] !== o_m_tdata[32*f +: 32]) begin
                            mismatches++;
                            if (mismatches <= 10) begin
                                $display("%s mismatch: expected %h, got %h",
                                         field_names[f], want[32*f +: 32],
                                         o_m_tdata[32*f +: 32]);
                            end
                        end
                    end
                end
            end
            if ((o_m_tvalid && i_m_tready) || (i_s_tvalid && o_s_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
                    $display("** elastic_circle_collision: FAILED **");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus sequence.
    // ---------------------------------------------------------------
    initial begin
        i_rst_n   = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed pairs: extremes, coincident centres, apart circles,
        // equal and lopsided masses, normals on the axes and in three quadrants.
        pairs_pending.push_back(pack_pair(0, 0, 32'h0001_0000, 0, 31'h1_0000, 31'h1_0000,
            0, 0, 0, 0, 31'h1_0000, 31'h1_0000));
        pairs_pending.push_back(pack_pair(0, 0, 32'h0002_0000, 0, 31'h1_0000, 31'h1_0000,
            32'h0001_8000, 0, 32'hFFFF_0000, 0, 31'h1_0000, 31'h1_0000));
        pairs_pending.push_back(pack_pair(0, 0, 32'h0002_0000, 32'h0001_0000, 31'h1_0000,
            31'h1_0000, 32'h0064_0000, 32'h0032_0000, 0, 0, 31'h1_0000, 31'h1_0000));
        pairs_pending.push_back(pack_pair(32'h0010_0000, 32'h0010_0000, 32'h0003_0000,
            32'hFFFD_0000, 31'h2_0000, 31'h1, 32'h000F_0000, 32'h000E_0000,
            32'hFFFF_0000, 32'h0005_0000, 31'h3_0000, 31'h7FFF_FFFF));
        pairs_pending.push_back(pack_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF));
        pairs_pending.push_back(pack_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 31'h1, 31'h1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 31'h1, 31'h1));
        pairs_pending.push_back(pack_pair(32'h8000_0000, 0, 32'h8000_0000, 0,
            31'h7FFF_FFFF, 31'h1, 32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 31'h7FFF_FFFF,
            31'h7FFF_FFFF));
        pairs_pending.push_back(pack_pair(0, 32'h7FFF_FFFF, 0, 32'h8000_0000, 31'h1,
            31'h7FFF_FFFF, 0, 32'h8000_0000, 0, 32'h7FFF_FFFF, 31'h1, 31'h1));
        pairs_pending.push_back(pack_pair(0, 0, 0, 0, 31'h1, 31'h1, 32'h1, 0, 0, 0,
            31'h1, 31'h1));
        pairs_pending.push_back(pack_pair(0, 0, 0, 0, 31'h1, 31'h1, 0, 32'hFFFF_FFFF,
            32'h1, 32'hFFFF_FFFF, 31'h1, 31'h1));
        pairs_pending.push_back(pack_pair(32'h0005_0000, 32'h0005_0000, 32'h0001_0000,
            32'h0001_0000, 31'h1_0000, 31'h1_0000, 32'hFFFB_0000, 32'hFFFB_0000,
            32'hFFFF_0000, 32'hFFFF_0000, 31'h1_0000, 31'h1_0000));
        pairs_pending.push_back(pack_pair(0, 0, 32'h0004_0000, 0, 31'h4_0000, 31'h1,
            32'hFFFF_D000, 32'h0003_0000, 0, 32'h0002_0000, 31'h4_0000, 31'h1));
        pairs_pending.push_back(pack_pair(32'h7FFF_FFFF, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            31'h7FFF_FFFF, 31'h1, 32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h8000_0000,
            31'h7FFF_FFFF, 31'h1));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        wait_idle();

        run_phase(200, 0, 0);
        run_phase(140, 70, 0);
        run_phase(140, 0, 70);
        run_phase(140, 12, 12);

        // Long receiver hold-off while the sender keeps offering pairs.
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_req <= hold_req + 1;
        repeat (130) add_random_pair();
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && collisions_due.size() == 0) begin
            $display("** elastic_circle_collision: PASSED **");
        end else begin
            $display("** elastic_circle_collision: FAILED **");
        end
        $finish;
    end

endmodule
